// ===== sv/wfhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wfhsp_pkg
// Shared types and constants for the frame header and SSID parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wfhsp_pkg;

   // Fixed 802.11 layout
   localparam int unsigned HEADER_BYTES       = 24;
   localparam int unsigned BEACON_FIXED_BYTES = 12;
   localparam int unsigned ADDR1_FIRST        = 4;
   localparam int unsigned ADDR2_FIRST        = 10;
   localparam int unsigned ADDR2_END          = 16;

   // Frame control codes (type field, subtype field)
   localparam logic [1:0] FC_TYPE_MGMT      = 2'd0;
   localparam logic [3:0] FC_SUB_PROBE_REQ  = 4'd4;
   localparam logic [3:0] FC_SUB_BEACON     = 4'd8;
   localparam logic [7:0] ELEMENT_ID_SSID   = 8'd0;

   // Register map
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam logic        REG_SSID_LIMIT = 1'b0;
   localparam logic [7:0]  SSID_LIMIT_RST = 8'd32;

   // Payload widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = 1;
   localparam int unsigned RSP_DATA_W = 128;

   // Element walk phase
   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_ID   = 2'd1,
      PHASE_LEN  = 2'd2
   } phase_type;

   // Result item, last field in the lowest bits
   typedef struct packed {
      logic [7:0]  ssid_size;
      logic [11:0] ssid_offset;
      logic        ssid_found;
      logic        beacon_seen;
      logic        probe_seen;
      logic        destination_valid;
      logic [47:0] destination_address;
      logic        source_valid;
      logic [47:0] source_address;
      logic        frame_valid;
   } rsp_type;

   localparam int unsigned RSP_PAD_W = RSP_DATA_W - $bits(rsp_type);

endpackage

`default_nettype wire

// ===== sv/wifi_frame_header_ssid_parser_unit.sv =====
// ----------------------------------------------------------------------------
// wifi_frame_header_ssid_parser_unit
// 802.11 MAC header and SSID element parser, one frame byte per transfer.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock on the request stream and, on the byte
// marked tlast, sends one summary transfer on the response stream. A byte
// is registered at the input and applied to the frame state unless a stall
// holds it; the summary is registered at the output, so rsp_tvalid rises in
// the cycle after the last byte is applied. One byte per cycle is sustained;
// the only stall is a summary still held in the output register when the
// next last byte is ready to be applied. The SSID length limit is set
// through the APB port and should be written only while no frame is in
// progress.
`default_nettype none

module wifi_frame_header_ssid_parser_unit #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [wfhsp_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] frame_byte
   input  wire logic [wfhsp_pkg::REQ_USER_W-1:0]   req_tuser,  // [0] first_byte
   input  wire logic                               req_tlast,  // last_byte
   // response stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [0] frame_valid, [48:1] source_address, [49] source_valid,
   // [97:50] destination_address, [98] destination_valid, [99] probe_seen,
   // [100] beacon_seen, [101] ssid_found, [113:102] ssid_offset,
   // [121:114] ssid_size, [127:122] zero
   output logic [wfhsp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // configuration
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [wfhsp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic               in_first_ff, in_first_in;
   logic               in_last_ff, in_last_in;
   logic               out_valid_ff, out_valid_in;
   wfhsp_pkg::rsp_type out_data_ff, out_data_in;
   wfhsp_pkg::rsp_type summary;
   logic [7:0]         ssid_limit;
   logic               step_en;

   wfhsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ssid_limit  (ssid_limit)
   );

   wfhsp_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .frame_byte (in_byte_ff),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .ssid_limit (ssid_limit),
      .summary    (summary)
   );

   // Advance the held byte unless it would overwrite a waiting summary
   assign step_en    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_first_in = in_first_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata[7:0];
         in_first_in = req_tuser[0];
         in_last_in  = req_tlast;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (step_en && in_last_ff) begin
         out_valid_in = 1'b1;
         out_data_in  = summary;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_first_ff <= in_first_in;
      in_last_ff  <= in_last_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{wfhsp_pkg::RSP_PAD_W{1'b0}}, out_data_ff};

   // A new summary only follows an applied last byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(step_en && in_last_ff))
      else $error("summary without a last byte");

   // Input stalls only while a held last byte waits behind an unsent summary
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && out_valid_ff))
      else $error("input stalled without cause");

   // A completed summary transfer with a last byte pending refills next cycle
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_last_ff && out_valid_ff && rsp_tready) |=> rsp_tvalid)
      else $error("summary dropped");

endmodule

`default_nettype wire

// ===== sv/wfhsp_csr.sv =====
// ----------------------------------------------------------------------------
// wfhsp_csr
// APB register block holding the SSID length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module wfhsp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [wfhsp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready,
   output logic [7:0]                             ssid_limit
);

   logic [7:0] limit_ff;
   logic [7:0] limit_in;
   logic       reg_index;
   logic       wr_hit;

   // Decode word index and write transfer
   assign reg_index  = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_index == wfhsp_pkg::REG_SSID_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (wr_hit) begin
         limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= wfhsp_pkg::SSID_LIMIT_RST;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      if (reg_index == wfhsp_pkg::REG_SSID_LIMIT) begin
         csr_prdata = {24'd0, limit_ff};
      end
   end

   assign ssid_limit = limit_ff;

endmodule

`default_nettype wire

// ===== sv/wfhsp_core.sv =====
// ----------------------------------------------------------------------------
// wfhsp_core
// Per-frame parse state: header capture, DS decode and element walk.
// ----------------------------------------------------------------------------
`default_nettype none

module wfhsp_core #(
   parameter int unsigned MAX_FRAME_BYTES = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        frame_byte,
   input  wire logic              first_byte,
   input  wire logic              last_byte,
   input  wire logic [7:0]        ssid_limit,
   output wfhsp_pkg::rsp_type     summary
);

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 2);
   localparam int unsigned NXT_W = $clog2(MAX_FRAME_BYTES + 257);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  probe_ff, probe_in;
   logic                  beacon_ff, beacon_in;
   logic                  to_ds_ff, to_ds_in;
   logic                  from_ds_ff, from_ds_in;
   logic [47:0]           addr1_ff, addr1_in;
   logic [47:0]           addr2_ff, addr2_in;
   logic [NXT_W-1:0]      next_off_ff, next_off_in;
   wfhsp_pkg::phase_type  phase_ff, phase_in;
   logic                  is_ssid_ff, is_ssid_in;
   logic                  stopped_ff, stopped_in;
   logic                  rec_found_ff, rec_found_in;
   logic [11:0]           rec_offset_ff, rec_offset_in;
   logic [7:0]            rec_length_ff, rec_length_in;

   // Updated values of the current byte, before the end-of-frame clear
   logic [POS_W-1:0]      pos_nx;
   logic                  probe_nx, beacon_nx, to_ds_nx, from_ds_nx;
   logic [47:0]           addr1_nx, addr2_nx;
   logic [NXT_W-1:0]      next_off_nx;
   wfhsp_pkg::phase_type  phase_nx;
   logic                  is_ssid_nx, stopped_nx, rec_found_nx;
   logic [11:0]           rec_offset_nx;
   logic [7:0]            rec_length_nx;
   logic [POS_W-1:0]      p;
   logic                  take;
   logic [NXT_W-1:0]      p_plus1;

   // Apply one byte to the frame state
   always_comb begin
      // start from a clean frame when marked first
      p             = first_byte ? '0 : pos_ff;
      probe_nx      = first_byte ? 1'b0 : probe_ff;
      beacon_nx     = first_byte ? 1'b0 : beacon_ff;
      to_ds_nx      = first_byte ? 1'b0 : to_ds_ff;
      from_ds_nx    = first_byte ? 1'b0 : from_ds_ff;
      addr1_nx      = first_byte ? '0 : addr1_ff;
      addr2_nx      = first_byte ? '0 : addr2_ff;
      next_off_nx   = first_byte ? '0 : next_off_ff;
      phase_nx      = first_byte ? wfhsp_pkg::PHASE_IDLE : phase_ff;
      is_ssid_nx    = first_byte ? 1'b0 : is_ssid_ff;
      stopped_nx    = first_byte ? 1'b0 : stopped_ff;
      rec_found_nx  = first_byte ? 1'b0 : rec_found_ff;
      rec_offset_nx = first_byte ? '0 : rec_offset_ff;
      rec_length_nx = first_byte ? '0 : rec_length_ff;

      take    = p < POS_W'(MAX_FRAME_BYTES);
      p_plus1 = NXT_W'(p) + NXT_W'(1);
      pos_nx  = (p <= POS_W'(MAX_FRAME_BYTES)) ? p + POS_W'(1) : p;

      if (take) begin
         // header fields
         if (p == '0) begin
            probe_nx  = (frame_byte[3:2] == wfhsp_pkg::FC_TYPE_MGMT)
                        && (frame_byte[7:4] == wfhsp_pkg::FC_SUB_PROBE_REQ);
            beacon_nx = (frame_byte[3:2] == wfhsp_pkg::FC_TYPE_MGMT)
                        && (frame_byte[7:4] == wfhsp_pkg::FC_SUB_BEACON);
            phase_nx  = wfhsp_pkg::PHASE_IDLE;
            if (probe_nx) begin
               next_off_nx = NXT_W'(wfhsp_pkg::HEADER_BYTES);
               phase_nx    = wfhsp_pkg::PHASE_ID;
            end else if (beacon_nx) begin
               next_off_nx = NXT_W'(wfhsp_pkg::HEADER_BYTES
                                    + wfhsp_pkg::BEACON_FIXED_BYTES);
               phase_nx    = wfhsp_pkg::PHASE_ID;
            end
         end else if (p == POS_W'(1)) begin
            to_ds_nx   = frame_byte[0];
            from_ds_nx = frame_byte[1];
         end else if (p >= POS_W'(wfhsp_pkg::ADDR1_FIRST)
                      && p < POS_W'(wfhsp_pkg::ADDR2_FIRST)) begin
            addr1_nx = {addr1_nx[39:0], frame_byte};
         end else if (p >= POS_W'(wfhsp_pkg::ADDR2_FIRST)
                      && p < POS_W'(wfhsp_pkg::ADDR2_END)) begin
            addr2_nx = {addr2_nx[39:0], frame_byte};
         end

         // element walk
         if (phase_nx == wfhsp_pkg::PHASE_ID && NXT_W'(p) == next_off_nx) begin
            is_ssid_nx = (frame_byte == wfhsp_pkg::ELEMENT_ID_SSID);
            phase_nx   = wfhsp_pkg::PHASE_LEN;
         end else if (phase_nx == wfhsp_pkg::PHASE_LEN) begin
            if (is_ssid_nx && frame_byte > ssid_limit) begin
               // oversize SSID: stop walking
               stopped_nx = 1'b1;
               phase_nx   = wfhsp_pkg::PHASE_IDLE;
            end else begin
               if (is_ssid_nx) begin
                  rec_found_nx  = 1'b1;
                  rec_offset_nx = 12'(p_plus1);
                  rec_length_nx = frame_byte;
               end
               next_off_nx = p_plus1 + NXT_W'(frame_byte);
               phase_nx    = wfhsp_pkg::PHASE_ID;
            end
         end
      end
   end

   // Register update: clear after the last byte of a frame
   always_comb begin
      pos_in        = pos_ff;
      probe_in      = probe_ff;
      beacon_in     = beacon_ff;
      to_ds_in      = to_ds_ff;
      from_ds_in    = from_ds_ff;
      addr1_in      = addr1_ff;
      addr2_in      = addr2_ff;
      next_off_in   = next_off_ff;
      phase_in      = phase_ff;
      is_ssid_in    = is_ssid_ff;
      stopped_in    = stopped_ff;
      rec_found_in  = rec_found_ff;
      rec_offset_in = rec_offset_ff;
      rec_length_in = rec_length_ff;
      if (step_en) begin
         if (last_byte) begin
            pos_in        = '0;
            probe_in      = 1'b0;
            beacon_in     = 1'b0;
            to_ds_in      = 1'b0;
            from_ds_in    = 1'b0;
            addr1_in      = '0;
            addr2_in      = '0;
            next_off_in   = '0;
            phase_in      = wfhsp_pkg::PHASE_IDLE;
            is_ssid_in    = 1'b0;
            stopped_in    = 1'b0;
            rec_found_in  = 1'b0;
            rec_offset_in = '0;
            rec_length_in = '0;
         end else begin
            pos_in        = pos_nx;
            probe_in      = probe_nx;
            beacon_in     = beacon_nx;
            to_ds_in      = to_ds_nx;
            from_ds_in    = from_ds_nx;
            addr1_in      = addr1_nx;
            addr2_in      = addr2_nx;
            next_off_in   = next_off_nx;
            phase_in      = phase_nx;
            is_ssid_in    = is_ssid_nx;
            stopped_in    = stopped_nx;
            rec_found_in  = rec_found_nx;
            rec_offset_in = rec_offset_nx;
            rec_length_in = rec_length_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         probe_ff      <= 1'b0;
         beacon_ff     <= 1'b0;
         to_ds_ff      <= 1'b0;
         from_ds_ff    <= 1'b0;
         addr1_ff      <= '0;
         addr2_ff      <= '0;
         next_off_ff   <= '0;
         phase_ff      <= wfhsp_pkg::PHASE_IDLE;
         is_ssid_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         rec_found_ff  <= 1'b0;
         rec_offset_ff <= '0;
         rec_length_ff <= '0;
      end else begin
         pos_ff        <= pos_in;
         probe_ff      <= probe_in;
         beacon_ff     <= beacon_in;
         to_ds_ff      <= to_ds_in;
         from_ds_ff    <= from_ds_in;
         addr1_ff      <= addr1_in;
         addr2_ff      <= addr2_in;
         next_off_ff   <= next_off_in;
         phase_ff      <= phase_in;
         is_ssid_ff    <= is_ssid_in;
         stopped_ff    <= stopped_in;
         rec_found_ff  <= rec_found_in;
         rec_offset_ff <= rec_offset_in;
         rec_length_ff <= rec_length_in;
      end
   end

   // Build the frame summary from the updated state
   always_comb begin
      summary = '0;
      if (pos_nx >= POS_W'(wfhsp_pkg::HEADER_BYTES)) begin
         summary.frame_valid = !stopped_nx && (pos_nx <= POS_W'(MAX_FRAME_BYTES));
         case ({to_ds_nx, from_ds_nx})
            2'b01: begin
               summary.source_address      = addr1_nx;
               summary.destination_address = addr2_nx;
               summary.source_valid        = 1'b1;
               summary.destination_valid   = 1'b1;
            end
            2'b10: begin
               summary.destination_address = addr1_nx;
               summary.source_address      = addr2_nx;
               summary.source_valid        = 1'b1;
               summary.destination_valid   = 1'b1;
            end
            2'b00: begin
               summary.source_address = addr2_nx;
               summary.source_valid   = 1'b1;
            end
            default: begin
               summary.source_valid      = 1'b0;
               summary.destination_valid = 1'b0;
            end
         endcase
         summary.probe_seen  = probe_nx;
         summary.beacon_seen = beacon_nx;
         if (rec_found_nx) begin
            summary.ssid_found  = 1'b1;
            summary.ssid_offset = rec_offset_nx;
            summary.ssid_size   = rec_length_nx;
         end
      end
   end

   // A stopped walk never resumes within the frame
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> phase_ff == wfhsp_pkg::PHASE_IDLE)
      else $error("element walk active after stop");

   // Position counter saturates one past the bound
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_FRAME_BYTES + 1))
      else $error("byte position beyond saturation");

   // Only one of probe and beacon can be seen
   assert property (@(posedge clock) disable iff (reset)
      !(probe_ff && beacon_ff))
      else $error("probe and beacon both flagged");

endmodule

`default_nettype wire
